/* hw/rtl/isq_pkg.sv */
`default_nettype none

package isq_pkg;

  // Default depth of the element store
  localparam int unsigned CAPACITY_DEF = 256;

  // Fixed field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FPOS_W = 8;
  localparam int unsigned CNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_SET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS,
    S_PUT,
    S_REM,
    S_FIND,
    S_FR,
    S_BK,
    S_DONE
  } state_e;

  // One result word
  typedef struct packed {
    status_e                   status;
    logic signed [VAL_W-1:0]   read_value;
    logic        [FPOS_W-1:0]  found_position;
    logic        [CNT_W-1:0]   element_count;
    logic signed [VAL_W-1:0]   front_value;
    logic signed [VAL_W-1:0]   back_value;
  } isq_result_t;

endpackage

`default_nettype wire

/* hw/rtl/isq_if.sv */
`default_nettype none

// Command channel
interface isq_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  cmd;
  logic        [8:0]  position;
  logic signed [31:0] operand_value;

  modport source (output valid, output cmd, output position, output operand_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input operand_value,
                  output ready);
endinterface

// Result channel
interface isq_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] read_value;
  logic        [7:0]  found_position;
  logic        [8:0]  element_count;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;

  modport source (output valid, output status, output read_value, output found_position,
                  output element_count, output front_value, output back_value,
                  input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input element_count, input front_value, input back_value,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/isq_ram.sv */
`default_nettype none

module isq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/isq_out_reg.sv */
`default_nettype none

module isq_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire isq_pkg::isq_result_t data_i,
  output      logic                 can_load_o,
  isq_rsp_if.source                 rsp_o
);

  import isq_pkg::*;

  logic        valid_q, valid_d;
  isq_result_t data_q;

  // Slot frees when the word is taken in the same cycle
  assign can_load_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.status         = data_q.status;
  assign rsp_o.read_value     = data_q.read_value;
  assign rsp_o.found_position = data_q.found_position;
  assign rsp_o.element_count  = data_q.element_count;
  assign rsp_o.front_value    = data_q.front_value;
  assign rsp_o.back_value     = data_q.back_value;

endmodule

`default_nettype wire

/* hw/rtl/indexed_sequence_store.sv */
// Commands are taken one at a time; insert and remove move each element between the
//   position and the end, and find compares the elements in turn, on the single
//   read/write port pair of the element RAM.
// Reset: count and control cleared asynchronously; element RAM is not cleared.
`default_nettype none

module indexed_sequence_store #(
  parameter int unsigned CAPACITY = isq_pkg::CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  isq_req_if.sink    req_i,
  isq_rsp_if.source  rsp_o
);

  import isq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  val_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              mv_pend_q, mv_pend_d;
  logic [AW-1:0]     mv_dst_q, mv_dst_d;
  logic              cap_rd_q, cap_rd_d;
  logic              cap_fr_q, cap_fr_d;
  logic              cap_bk_q, cap_bk_d;
  logic              cmp_pend_q, cmp_pend_d;
  logic [CW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [VAL_W-1:0]  rd_q, rd_d;
  logic [VAL_W-1:0]  front_q, front_d;
  logic [VAL_W-1:0]  back_q, back_d;
  status_e           status_q, status_d;
  logic [CW-1:0]     fpos_q, fpos_d;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  logic              out_can_load, out_load;
  isq_result_t       out_word;

  // Shared conditions
  logic [CW-1:0]     pos_c, idx_m1, cnt_m1;
  logic              ins_bad, acc_bad, is_full, match, at_pos, at_end;
  logic [VAL_W-1:0]  rd_now, back_now;

  assign pos_c   = CW'(pos_q);
  assign idx_m1  = idx_q - CW'(1);
  assign cnt_m1  = count_q - CW'(1);
  assign ins_bad = PW'(pos_q) > PW'(count_q);
  assign acc_bad = PW'(pos_q) >= PW'(count_q);
  assign is_full = count_q == CW'(CAPACITY);
  assign match   = cmp_pend_q && (ram_rdata == val_q);
  assign at_pos  = idx_q == pos_c;
  assign at_end  = idx_q == count_q;
  assign rd_now  = cap_rd_q ? ram_rdata : rd_q;
  assign back_now = cap_bk_q ? ram_rdata : back_q;

  assign req_i.ready = state_q == S_IDLE;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_e'(cmd_q))
          CMD_APPEND: state_d = is_full ? S_DONE : S_FR;
          CMD_INSERT: state_d = (ins_bad || is_full) ? S_DONE : S_INS;
          CMD_SET:    state_d = acc_bad ? S_DONE : S_FR;
          CMD_REMOVE: state_d = acc_bad ? S_DONE : S_REM;
          CMD_FIND:   state_d = S_FIND;
          default:    state_d = S_DONE;
        endcase
      end
      S_INS: begin
        if (at_pos) begin
          state_d = S_PUT;
        end
      end
      S_PUT: state_d = S_FR;
      S_REM: begin
        if (at_end) begin
          state_d = S_FR;
        end
      end
      S_FIND: begin
        if (match || at_end) begin
          state_d = S_DONE;
        end
      end
      S_FR:   state_d = (count_q == '0) ? S_DONE : S_BK;
      S_BK:   state_d = S_DONE;
      S_DONE: begin
        if (out_can_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    mv_pend_d  = 1'b0;
    mv_dst_d   = mv_dst_q;
    cap_rd_d   = 1'b0;
    cap_fr_d   = 1'b0;
    cap_bk_d   = 1'b0;
    cmp_pend_d = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    rd_d       = cap_rd_q ? ram_rdata : rd_q;
    front_d    = cap_fr_q ? ram_rdata : front_q;
    back_d     = cap_bk_q ? ram_rdata : back_q;
    status_d   = status_q;
    fpos_d     = fpos_q;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[AW-1:0];
    // a pending shift writes back last cycle's read word
    ram_we     = mv_pend_q;
    ram_waddr  = mv_dst_q;
    ram_wdata  = ram_rdata;
    out_load   = 1'b0;

    unique case (state_q)
      S_DISP: begin
        status_d = ST_OK;
        rd_d     = '0;
        fpos_d   = '0;
        unique case (cmd_e'(cmd_q))
          CMD_APPEND: begin
            if (is_full) begin
              status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = val_q;
              count_d   = count_q + CW'(1);
            end
          end
          CMD_INSERT: begin
            if (ins_bad) begin
              status_d = ST_RANGE;
            end else if (is_full) begin
              status_d = ST_FULL;
            end else begin
              idx_d = count_q;
            end
          end
          CMD_SET: begin
            if (acc_bad) begin
              status_d = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_c[AW-1:0];
              ram_wdata = val_q;
            end
          end
          CMD_REMOVE: begin
            if (acc_bad) begin
              status_d = ST_RANGE;
            end else begin
              idx_d = pos_c;
            end
          end
          CMD_GET: begin
            if (acc_bad) begin
              status_d = ST_RANGE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = pos_c[AW-1:0];
              cap_rd_d  = 1'b1;
            end
          end
          CMD_FIND: begin
            status_d = ST_NOTFOUND;
            idx_d    = '0;
          end
          CMD_CLEAR: begin
            count_d = '0;
            front_d = '0;
            back_d  = '0;
          end
          default: ;
        endcase
      end
      // shift up: read idx-1, write it to idx next cycle
      S_INS: begin
        if (!at_pos) begin
          ram_re    = 1'b1;
          ram_raddr = idx_m1[AW-1:0];
          mv_pend_d = 1'b1;
          mv_dst_d  = idx_q[AW-1:0];
          idx_d     = idx_m1;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_c[AW-1:0];
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
      end
      // shift down: first read returns the removed word
      S_REM: begin
        if (!at_end) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AW-1:0];
          mv_pend_d = !at_pos;
          mv_dst_d  = idx_m1[AW-1:0];
          cap_rd_d  = at_pos;
          idx_d     = idx_q + CW'(1);
        end else begin
          count_d = cnt_m1;
        end
      end
      // linear scan, compare in the cycle after the read
      S_FIND: begin
        if (match) begin
          status_d = ST_OK;
          fpos_d   = cmp_idx_q;
        end else if (!at_end) begin
          ram_re     = 1'b1;
          ram_raddr  = idx_q[AW-1:0];
          cmp_pend_d = 1'b1;
          cmp_idx_d  = idx_q;
          idx_d      = idx_q + CW'(1);
        end
      end
      // refresh front and back after a change
      S_FR: begin
        if (count_q == '0) begin
          front_d = '0;
          back_d  = '0;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          cap_fr_d  = 1'b1;
        end
      end
      S_BK: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_m1[AW-1:0];
        cap_bk_d  = 1'b1;
      end
      S_DONE: begin
        out_load = out_can_load;
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    out_word.status         = status_q;
    out_word.read_value     = rd_now;
    out_word.found_position = FPOS_W'(fpos_q);
    out_word.element_count  = CNT_W'(count_q);
    out_word.front_value    = front_q;
    out_word.back_value     = back_now;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      mv_pend_q  <= 1'b0;
      cap_rd_q   <= 1'b0;
      cap_fr_q   <= 1'b0;
      cap_bk_q   <= 1'b0;
      cmp_pend_q <= 1'b0;
      front_q    <= '0;
      back_q     <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      mv_pend_q  <= mv_pend_d;
      cap_rd_q   <= cap_rd_d;
      cap_fr_q   <= cap_fr_d;
      cap_bk_q   <= cap_bk_d;
      cmp_pend_q <= cmp_pend_d;
      front_q    <= front_d;
      back_q     <= back_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q <= req_i.cmd;
      pos_q <= req_i.position;
      val_q <= req_i.operand_value;
    end
    idx_q     <= idx_d;
    mv_dst_q  <= mv_dst_d;
    cmp_idx_q <= cmp_idx_d;
    rd_q      <= rd_d;
    status_q  <= status_d;
    fpos_q    <= fpos_d;
  end

  isq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  isq_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .data_i     (out_word),
    .can_load_o (out_can_load),
    .rsp_o      (rsp_o)
  );

  // Checks
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP || state_q == S_PUT) |-> !mv_pend_q)
    else $error("shift write-back overlaps a direct write");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of one entry in the same cycle");

  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_DISP))
    else $error("accepted word not dispatched");

endmodule

`default_nettype wire

/* dv/indexed_sequence_store_tb.sv */
`timescale 1ns / 1ps

module indexed_sequence_store_tb;
  import isq_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VPAT = 32'shAAAA_AAAA;
  localparam int BIAS_MIX = 0;
  localparam int BIAS_GROW = 1;
  localparam int BIAS_SHRINK = 2;
  localparam int unsigned N_DIR = 25;
  localparam int unsigned RANDOM_WORDS = 1225;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned TAIL_CYCLES = 300;

  // Directed row: command plus a hand-written result where it is obvious
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic                    typed;
    status_e                 st;
    logic signed [VAL_W-1:0] rd;
    logic [CNT_W-1:0]        cnt;
    logic signed [VAL_W-1:0] front;
    logic signed [VAL_W-1:0] back;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    // empty store: every position is out of range for get, set and remove, nothing to find
    '{CMD_GET,    9'd0,   32'sd0,      1'b1, ST_RANGE,    32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_REMOVE, 9'd0,   32'sd0,      1'b1, ST_RANGE,    32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_FIND,   9'd0,   32'sd0,      1'b1, ST_NOTFOUND, 32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_UNUSED, 9'h1FF, -32'sd1,     1'b1, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_INSERT, 9'd1,   32'sd9,      1'b1, ST_RANGE,    32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_SET,    9'd0,   32'sd5,      1'b1, ST_RANGE,    32'sd0, 9'd0, 32'sd0, 32'sd0},
    // value extremes, insert at front and at the end
    '{CMD_APPEND, 9'd0,   VMAX,        1'b1, ST_OK,       32'sd0, 9'd1, VMAX,   VMAX},
    '{CMD_INSERT, 9'd0,   VMIN,        1'b1, ST_OK,       32'sd0, 9'd2, VMIN,   VMAX},
    '{CMD_INSERT, 9'd2,   32'sd0,      1'b1, ST_OK,       32'sd0, 9'd3, VMIN,   32'sd0},
    '{CMD_SET,    9'd1,   -32'sd1,     1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_GET,    9'd1,   32'sd0,      1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_FIND,   9'd0,   -32'sd1,     1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_APPEND, 9'd0,   32'sh5555_5555, 1'b0, ST_OK,    32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_APPEND, 9'd0,   VPAT,        1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    // errors with five elements held
    '{CMD_SET,    9'd5,   32'sd1,      1'b1, ST_RANGE,    32'sd0, 9'd5, VMIN,   VPAT},
    '{CMD_GET,    9'd256, 32'sd0,      1'b1, ST_RANGE,    32'sd0, 9'd5, VMIN,   VPAT},
    '{CMD_INSERT, 9'd256, 32'sd3,      1'b1, ST_RANGE,    32'sd0, 9'd5, VMIN,   VPAT},
    '{CMD_FIND,   9'd0,   32'sh1234_5678, 1'b1, ST_NOTFOUND, 32'sd0, 9'd5, VMIN, VPAT},
    // drop the last element, then the first
    '{CMD_REMOVE, 9'd4,   32'sd0,      1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_REMOVE, 9'd0,   32'sd0,      1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_UNUSED, 9'd3,   32'sd77,     1'b0, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    '{CMD_CLEAR,  9'd0,   32'sd0,      1'b1, ST_OK,       32'sd0, 9'd0, 32'sd0, 32'sd0},
    // removing the only element empties front and back
    '{CMD_APPEND, 9'd0,   32'sd7,      1'b1, ST_OK,       32'sd0, 9'd1, 32'sd7, 32'sd7},
    '{CMD_REMOVE, 9'd0,   32'sd0,      1'b1, ST_OK,       32'sd7, 9'd0, 32'sd0, 32'sd0},
    '{CMD_FIND,   9'd0,   32'sd7,      1'b1, ST_NOTFOUND, 32'sd0, 9'd0, 32'sd0, 32'sd0}
  };

  logic clk;
  logic rst_n;

  isq_req_if req_if ();
  isq_rsp_if rsp_if ();

  indexed_sequence_store #(.CAPACITY(CAPACITY)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the sequence, advanced when a command word is accepted
  logic signed [VAL_W-1:0] seq_mem [CAPACITY];
  int unsigned seq_count;

  isq_result_t result_q [$];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned error_count;
  bit sender_quiet;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Expected result of one command; updates the shadow sequence
  function automatic isq_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [VAL_W-1:0] val);
    isq_result_t r;
    int unsigned i;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (seq_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          seq_mem[seq_count] = val;
          seq_count++;
        end
      end
      CMD_INSERT: begin
        if (pos > seq_count) begin
          r.status = ST_RANGE;
        end else if (seq_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = seq_count; i > pos; i--) seq_mem[i] = seq_mem[i-1];
          seq_mem[pos] = val;
          seq_count++;
        end
      end
      CMD_SET: begin
        if (pos >= seq_count) r.status = ST_RANGE;
        else seq_mem[pos] = val;
      end
      CMD_REMOVE: begin
        if (pos >= seq_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = seq_mem[pos];
          for (i = pos; i + 1 < seq_count; i++) seq_mem[i] = seq_mem[i+1];
          seq_count--;
        end
      end
      CMD_GET: begin
        if (pos >= seq_count) r.status = ST_RANGE;
        else r.read_value = seq_mem[pos];
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < seq_count; i++) begin
          if (seq_mem[i] == val) begin
            r.status = ST_OK;
            r.found_position = i[FPOS_W-1:0];
            break;
          end
        end
      end
      CMD_CLEAR: seq_count = 0;
      default: ;
    endcase
    r.element_count = seq_count[CNT_W-1:0];
    if (seq_count > 0) begin
      r.front_value = seq_mem[0];
      r.back_value = seq_mem[seq_count-1];
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int bias);
    int unsigned r, grow_w, shrink_w;
    r = $urandom_range(0, 999);
    grow_w = (bias == BIAS_GROW) ? 300 : (bias == BIAS_MIX) ? 150 : 60;
    shrink_w = (bias == BIAS_SHRINK) ? 450 : (bias == BIAS_GROW) ? 80 : 170;
    if (r < 5) return CMD_CLEAR;
    if (r < 10) return CMD_UNUSED;
    r -= 10;
    if (r < grow_w) return CMD_APPEND;
    r -= grow_w;
    if (r < grow_w) return CMD_INSERT;
    r -= grow_w;
    if (r < shrink_w) return CMD_REMOVE;
    case (r % 3)
      0: return CMD_SET;
      1: return CMD_GET;
      default: return CMD_FIND;
    endcase
  endfunction

  // Mostly in range; otherwise the first bad position, the top, or noise
  function automatic logic [POS_W-1:0] pick_pos(input logic [CMD_W-1:0] cmd);
    int unsigned r, top;
    bit is_ins;
    is_ins = (cmd == CMD_INSERT);
    r = $urandom_range(0, 99);
    if (r < 85 && (is_ins || seq_count > 0)) begin
      top = is_ins ? seq_count : seq_count - 1;
      return POS_W'($urandom_range(0, top));
    end
    if (r < 93) return POS_W'(is_ins ? seq_count + 1 : seq_count);
    if (r < 96) return POS_W'(CAPACITY);
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Values: copies of stored ones (duplicates, find hits), corners, or random
  function automatic logic signed [VAL_W-1:0] pick_val(input bit hit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (seq_count > 0 && r < (hit ? 60 : 20)) return seq_mem[$urandom_range(0, seq_count - 1)];
    if (r >= 80) begin
      case ($urandom_range(0, 3))
        0: return VMIN;
        1: return VMAX;
        2: return -32'sd1;
        default: return $urandom_range(0, 3);
      endcase
    end
    return $urandom;
  endfunction

  // Offer one command word; predict its result once accepted
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val, input bit typed,
                           input isq_result_t want);
    int unsigned gap;
    isq_result_t predicted;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.position <= pos;
    req_if.operand_value <= val;
    do @(posedge clk); while (!req_if.ready);
    predicted = apply_command(cmd, pos, val);
    result_q.insert(result_q.size(), typed ? want : predicted);
    words_sent++;
  endtask

  task automatic run_burst(input int unsigned n, input int bias);
    logic [CMD_W-1:0] c;
    sender_quiet = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      c = pick_cmd(bias);
      send_word(c, pick_pos(c), pick_val(c == CMD_FIND), 1'b0, '0);
    end
  endtask

  // Stop offering until every outstanding result is back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Stimulus
  initial begin
    isq_result_t want;
    logic [CMD_W-1:0] c;
    int unsigned r;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_APPEND;
    req_if.position = '0;
    req_if.operand_value = '0;
    seq_count = 0;
    words_sent = 0;
    sender_quiet = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int k = 0; k < N_DIR; k++) begin
      want = '0;
      want.status = DIR_TABLE[k].st;
      want.read_value = DIR_TABLE[k].rd;
      want.element_count = DIR_TABLE[k].cnt;
      want.front_value = DIR_TABLE[k].front;
      want.back_value = DIR_TABLE[k].back;
      send_word(DIR_TABLE[k].cmd, DIR_TABLE[k].pos, DIR_TABLE[k].val, DIR_TABLE[k].typed,
                want);
    end
    wait_drained();

    // mixed traffic with drifting fill level
    while (words_sent < N_DIR + 300) run_burst($urandom_range(8, 40), $urandom_range(0, 2));
    wait_drained();

    // grow to full, mostly appends and inserts, a few reads
    while (seq_count < CAPACITY) begin
      if (words_sent % 32 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) c = CMD_SET;
      else if (r < 7) c = CMD_GET;
      else if (r < 10) c = CMD_FIND;
      else if (r < 55) c = CMD_APPEND;
      else c = CMD_INSERT;
      send_word(c, pick_pos(c), pick_val(c == CMD_FIND), 1'b0, '0);
    end

    // at capacity: adds must be refused, reads still work
    repeat (24) begin
      case ($urandom_range(0, 4))
        0: c = CMD_APPEND;
        1: c = CMD_INSERT;
        2: c = CMD_SET;
        3: c = CMD_GET;
        default: c = CMD_FIND;
      endcase
      send_word(c, pick_pos(c), pick_val(c == CMD_FIND), 1'b0, '0);
    end

    // drain the store mostly by removes
    while (seq_count > 16) begin
      if (words_sent % 32 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) c = CMD_REMOVE;
      else if (r < 83) c = CMD_GET;
      else if (r < 91) c = CMD_SET;
      else c = CMD_FIND;
      send_word(c, pick_pos(c), pick_val(c == CMD_FIND), 1'b0, '0);
    end

    // more mixed traffic for the rest
    while (words_sent < N_DIR + RANDOM_WORDS)
      run_burst($urandom_range(8, 40), $urandom_range(0, 2));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random back-pressure and the compare against the oldest prediction
  initial begin
    isq_result_t got;
    isq_result_t want;
    int unsigned hold_left;
    bit rx_quiet;
    bit long_hold_done;
    bit took;
    hold_left = 0;
    rx_quiet = 1'b0;
    long_hold_done = 1'b0;
    results_seen = 0;
    error_count = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = rsp_if.valid && rsp_if.ready;
      if (took) begin
        got.status = status_e'(rsp_if.status);
        got.read_value = rsp_if.read_value;
        got.found_position = rsp_if.found_position;
        got.element_count = rsp_if.element_count;
        got.front_value = rsp_if.front_value;
        got.back_value = rsp_if.back_value;
        results_seen++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word: st=%0d rd=%0d fp=%0d cnt=%0d fr=%0d bk=%0d",
                   $time, got.status, got.read_value, got.found_position,
                   got.element_count, got.front_value, got.back_value);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d rd=%0d fp=%0d cnt=%0d fr=%0d bk=%0d",
                     $time, want.status, want.read_value, want.found_position,
                     want.element_count, want.front_value, want.back_value);
            $display("%0t:          actual   st=%0d rd=%0d fp=%0d cnt=%0d fr=%0d bk=%0d",
                     $time, got.status, got.read_value, got.found_position,
                     got.element_count, got.front_value, got.back_value);
            error_count++;
          end
        end
      end

      // one long hold-off so the block backs up onto its input
      if (hold_left == 0 && !long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && (took || $urandom_range(0, 19) == 0)) begin
        hold_left = pick_gap(rx_quiet);
      end
      if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;

      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #(40_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* indexed_sequence_store.f */
hw/rtl/isq_pkg.sv
hw/rtl/isq_if.sv
hw/rtl/isq_ram.sv
hw/rtl/isq_out_reg.sv
hw/rtl/indexed_sequence_store.sv
dv/indexed_sequence_store_tb.sv
